/* hdl/bp2pp_pkg.sv */
// shared constants and types for the bitplane to packed pixel converter
`timescale 1ns / 1ps

package bp2pp_pkg;

   localparam int MAX_PLANE_BYTES = 8;
   localparam int MAX_PLANES      = 8;
   localparam int BUF_DEPTH       = MAX_PLANE_BYTES * MAX_PLANES;
   localparam int BUF_AW          = $clog2(BUF_DEPTH);
   localparam int BYTE_W          = 8;
   localparam int PIX_W           = 8;
   localparam int CNT_W           = 7;
   localparam int LANE_IW         = $clog2(MAX_PLANES);
   localparam int BIT_IW          = $clog2(BYTE_W);
   localparam int CFG_W           = 4;
   localparam int CSR_IW          = 2;

   localparam logic [BIT_IW-1:0] BIT_LAST = 3'd7;

   // register indexes on the csr port
   localparam logic [CSR_IW-1:0] CSR_PLANE_BYTES     = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_BITS_PER_PIXEL  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MSB_PLANE_FIRST = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] PLANE_BYTES_RST    = 4'd1;
   localparam logic [CFG_W-1:0] BITS_PER_PIXEL_RST = 4'd4;

   // controls for the plane shift lanes
   typedef struct packed {
      logic                  load;
      logic [LANE_IW-1:0]    load_lane;
      logic                  shift;
      logic [MAX_PLANES-1:0] lane_mask;
   } lane_ctl_type;

endpackage

/* hdl/bp2pp_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps

interface bp2pp_req_if;
   import bp2pp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface bp2pp_rsp_if;
   import bp2pp_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_index;
   logic             last_of_group;

   modport source (output valid, output pixel_index, output last_of_group, input ready);
   modport sink   (input valid, input pixel_index, input last_of_group, output ready);
endinterface

/* hdl/bp2pp_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bp2pp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bp2pp_planes.sv */
// per-plane shift lanes, one bit of every plane leaves per shift
`timescale 1ns / 1ps

module bp2pp_planes (
   input  logic                           clock,
   input  bp2pp_pkg::lane_ctl_type        ctl,
   input  logic [bp2pp_pkg::BYTE_W-1:0]   rd_data,
   output logic [bp2pp_pkg::PIX_W-1:0]    pixel
);
   import bp2pp_pkg::*;

   logic [MAX_PLANES-1:0][BYTE_W-1:0] lanes_ff;
   logic [MAX_PLANES-1:0][BYTE_W-1:0] lanes_in;

   always_comb begin
      for (int i = 0; i < MAX_PLANES; i++) begin
         if (ctl.load && (ctl.load_lane == LANE_IW'(i))) begin
            lanes_in[i] = rd_data;
         end else if (ctl.shift) begin
            lanes_in[i] = {lanes_ff[i][BYTE_W-2:0], 1'b0};
         end else begin
            lanes_in[i] = lanes_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
   end

   // lanes are loaded already in weight order, so lane i drives pixel bit i
   always_comb begin
      pixel = '0;
      for (int i = 0; i < MAX_PLANES; i++) begin
         pixel[i] = lanes_ff[i][BYTE_W-1] & ctl.lane_mask[i];
      end
   end

endmodule

/* hdl/bp2pp_ctrl.sv */
// byte collection, plane load sequencing and pixel output register
`timescale 1ns / 1ps

module bp2pp_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   bp2pp_req_if.sink                       req_bus,
   bp2pp_rsp_if.source                     rsp_bus,
   input  logic [bp2pp_pkg::CFG_W-1:0]     plane_bytes,
   input  logic [bp2pp_pkg::CFG_W-1:0]     bits_per_pixel,
   input  logic                            msb_plane_first,
   output logic                            wr_en,
   output logic [bp2pp_pkg::BUF_AW-1:0]    wr_addr,
   output logic [bp2pp_pkg::BYTE_W-1:0]    wr_data,
   output logic                            rd_en,
   output logic [bp2pp_pkg::BUF_AW-1:0]    rd_addr,
   output bp2pp_pkg::lane_ctl_type         lane_ctl,
   input  logic [bp2pp_pkg::PIX_W-1:0]     pixel
);
   import bp2pp_pkg::*;

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_LOAD    = 3'b010,
      ST_SHIFT   = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CFG_W-1:0]   plane_ff, plane_in;
   logic [LANE_IW-1:0] col_ff, col_in;
   logic [BIT_IW-1:0]  bit_ff, bit_in;
   logic               load_vld_ff, load_vld_in;
   logic [LANE_IW-1:0] load_lane_ff, load_lane_in;
   logic               out_vld_ff, out_vld_in;
   logic [PIX_W-1:0]   out_pix_ff, out_pix_in;
   logic               out_last_ff, out_last_in;

   logic               accept;
   logic [CNT_W-1:0]   cnt_base;
   logic [CNT_W-1:0]   cnt_next;
   logic [CNT_W-1:0]   group_size;
   logic               issue;
   logic [CFG_W-1:0]   lane_pos;
   logic [CNT_W-1:0]   plane_offset;
   logic               last_col;
   logic               emit;

   assign group_size   = CNT_W'(plane_bytes * bits_per_pixel);
   assign accept       = req_bus.valid && req_bus.ready;
   assign cnt_base     = req_bus.frame_start ? '0 : cnt_ff;
   assign cnt_next     = cnt_base + CNT_W'(1);
   assign issue        = (plane_ff < bits_per_pixel);
   assign lane_pos     = msb_plane_first ? (bits_per_pixel - CFG_W'(1) - plane_ff) : plane_ff;
   assign plane_offset = CNT_W'(plane_ff[LANE_IW-1:0] * plane_bytes);
   assign last_col     = ({1'b0, col_ff} == (plane_bytes - CFG_W'(1)));
   assign emit         = !out_vld_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_COLLECT);
   assign wr_en         = accept;
   assign wr_addr       = cnt_base[BUF_AW-1:0];
   assign wr_data       = req_bus.data_byte;
   assign rd_en         = (state_ff == ST_LOAD) && issue;
   assign rd_addr       = BUF_AW'(plane_offset + CNT_W'(col_ff));

   always_comb begin
      lane_ctl.load      = load_vld_ff;
      lane_ctl.load_lane = load_lane_ff;
      lane_ctl.shift     = (state_ff == ST_SHIFT) && emit;
      for (int i = 0; i < MAX_PLANES; i++) begin
         lane_ctl.lane_mask[i] = (CFG_W'(i) < bits_per_pixel);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      plane_in     = plane_ff;
      col_in       = col_ff;
      bit_in       = bit_ff;
      load_vld_in  = 1'b0;
      load_lane_in = load_lane_ff;
      out_vld_in   = out_vld_ff && !rsp_bus.ready;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (cnt_next >= group_size) begin
                  cnt_in   = '0;
                  plane_in = '0;
                  col_in   = '0;
                  bit_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cnt_in = cnt_next;
               end
            end
         end
         ST_LOAD: begin
            // one plane byte read per cycle, captured by the lanes in the cycle after the read
            if (issue) begin
               plane_in     = plane_ff + CFG_W'(1);
               load_vld_in  = 1'b1;
               load_lane_in = lane_pos[LANE_IW-1:0];
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (emit) begin
               out_vld_in  = 1'b1;
               out_pix_in  = pixel;
               out_last_in = last_col && (bit_ff == BIT_LAST);
               bit_in      = bit_ff + BIT_IW'(1);
               if (bit_ff == BIT_LAST) begin
                  if (last_col) begin
                     col_in   = '0;
                     state_in = ST_COLLECT;
                  end else begin
                     col_in   = col_ff + LANE_IW'(1);
                     plane_in = '0;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_COLLECT;
         cnt_ff      <= '0;
         plane_ff    <= '0;
         col_ff      <= '0;
         bit_ff      <= '0;
         load_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         plane_ff    <= plane_in;
         col_ff      <= col_in;
         bit_ff      <= bit_in;
         load_vld_ff <= load_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      load_lane_ff <= load_lane_in;
      out_pix_ff   <= out_pix_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.pixel_index   = out_pix_ff;
   assign rsp_bus.last_of_group = out_last_ff;

endmodule

/* hdl/bitplane_to_packed_pixels.sv */
// top level of the bitplane to packed pixel converter
`timescale 1ns / 1ps

// Planar image bytes come in on req_bus (valid/ready), one byte per request;
// frame_start restarts the group so a partial group is dropped. A group is
// bits_per_pixel planes of plane_bytes bytes each, stored in a 64 x 8 ram.
// While collecting, req_bus.ready is high. Once the last byte of a
// group is taken, req_bus.ready drops and the group is sent on rsp_bus as
// plane_bytes*8 pixel indices, last_of_group set on the final one.
// For each byte column the planes are read from the ram one per cycle into
// per-plane shift lanes, then shifted out one pixel per cycle unless the
// receiver stalls. Throughput is set by the single ram read port and the
// one-bit-per-cycle shift lanes.
// rsp_bus has an output register: a stalled receiver holds the current
// pixel and freezes the lanes, nothing is lost. Collection of the next
// group resumes while the final pixel still waits in the output register.
// csr writes (index 0 plane_bytes, 1 bits_per_pixel, 2 msb_plane_first)
// take effect at once and belong in idle time. Synchronous reset returns
// to collecting with an empty group and reset register values.

module bitplane_to_packed_pixels (
   input  logic                          clock,
   input  logic                          reset,
   bp2pp_req_if.sink                     req_bus,
   bp2pp_rsp_if.source                   rsp_bus,
   input  logic                          csr_we,
   input  logic [bp2pp_pkg::CSR_IW-1:0]  csr_index,
   input  logic [bp2pp_pkg::CFG_W-1:0]   csr_wdata
);
   import bp2pp_pkg::*;

   logic [CFG_W-1:0] plane_bytes_ff;
   logic [CFG_W-1:0] bits_per_pixel_ff;
   logic             msb_plane_first_ff;
   logic [CFG_W-1:0] plane_bytes_cl;
   logic [CFG_W-1:0] bits_per_pixel_cl;

   logic              wr_en;
   logic [BUF_AW-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [BUF_AW-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   lane_ctl_type      lane_ctl;
   logic [PIX_W-1:0]  pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_bytes_ff     <= PLANE_BYTES_RST;
         bits_per_pixel_ff  <= BITS_PER_PIXEL_RST;
         msb_plane_first_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANE_BYTES:     plane_bytes_ff     <= csr_wdata;
            CSR_BITS_PER_PIXEL:  bits_per_pixel_ff  <= csr_wdata;
            CSR_MSB_PLANE_FIRST: msb_plane_first_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      if (plane_bytes_ff == '0) begin
         plane_bytes_cl = CFG_W'(1);
      end else if (plane_bytes_ff > CFG_W'(MAX_PLANE_BYTES)) begin
         plane_bytes_cl = CFG_W'(MAX_PLANE_BYTES);
      end else begin
         plane_bytes_cl = plane_bytes_ff;
      end
      if (bits_per_pixel_ff == '0) begin
         bits_per_pixel_cl = CFG_W'(1);
      end else if (bits_per_pixel_ff > CFG_W'(MAX_PLANES)) begin
         bits_per_pixel_cl = CFG_W'(MAX_PLANES);
      end else begin
         bits_per_pixel_cl = bits_per_pixel_ff;
      end
   end

   bp2pp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_DEPTH)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bp2pp_planes u_planes (
      .clock   (clock),
      .ctl     (lane_ctl),
      .rd_data (rd_data),
      .pixel   (pixel)
   );

   bp2pp_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .plane_bytes     (plane_bytes_cl),
      .bits_per_pixel  (bits_per_pixel_cl),
      .msb_plane_first (msb_plane_first_ff),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .lane_ctl        (lane_ctl),
      .pixel           (pixel)
   );

endmodule

/* dv/tb_bitplane_to_packed_pixels.sv */
// self-checking testbench for the bitplane to packed pixel converter
`timescale 1ns / 1ps

module tb_bitplane_to_packed_pixels;
   import bp2pp_pkg::*;

   localparam int DRAIN_CYCLES = 160;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
   } plane_byte_type;

   typedef struct packed {
      logic [PIX_W-1:0] index;
      logic             last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   bp2pp_req_if req_if ();
   bp2pp_rsp_if rsp_if ();

   bitplane_to_packed_pixels u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the converter state
   logic [BYTE_W-1:0] grp_buf [BUF_DEPTH];
   logic [CNT_W-1:0]  grp_count;
   logic [CFG_W-1:0]  cfg_plane_bytes;
   logic [CFG_W-1:0]  cfg_bits_per_pixel;
   logic              cfg_msb_first;

   plane_byte_type byte_q [$];
   pixel_type      pixel_q [$];
   int             bytes_queued = 0;
   int             bytes_taken = 0;
   int             mismatch_count = 0;

   bit req_took = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int run_left = 0;
   bit run_ready = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // collect one byte and, on a full group, push the pixels it releases
   task automatic predict_pixels(input logic [BYTE_W-1:0] data, input logic fs);
      int        pb;
      int        bpp;
      int        idx;
      int        sh;
      pixel_type p;
      pb  = clamp_cfg(cfg_plane_bytes, MAX_PLANE_BYTES);
      bpp = clamp_cfg(cfg_bits_per_pixel, MAX_PLANES);
      if (fs) grp_count = '0;
      grp_buf[grp_count % BUF_DEPTH] = data;
      grp_count = grp_count + 1'b1;
      if (grp_count >= pb * bpp) begin
         for (int j = 0; j < pb * 8; j++) begin
            p.index = '0;
            for (int k = 0; k < bpp; k++) begin
               idx = (k * pb + j / 8) % BUF_DEPTH;
               sh  = cfg_msb_first ? (bpp - 1 - k) : k;
               p.index[sh] = grp_buf[idx][7 - (j % 8)];
            end
            p.last = (j == pb * 8 - 1);
            pixel_q.push_back(p);
         end
         grp_count = '0;
      end
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic fs);
      plane_byte_type b;
      b.data_byte   = data;
      b.frame_start = fs;
      byte_q.push_back(b);
      bytes_queued++;
   endtask

   // wait until every request is taken and every pixel is back
   task automatic wait_drained();
      while (bytes_taken != bytes_queued || pixel_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all three registers on successive cycles, block is idle here
   task automatic set_config(input logic [CFG_W-1:0] pb, input logic [CFG_W-1:0] bpp,
                             input logic msb);
      logic [CFG_W-1:0] msb_word;
      msb_word = {3'($urandom_range(0, 7)), msb};
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_PLANE_BYTES;
      csr_wdata <= pb;
      cfg_plane_bytes = pb;
      @(negedge clock);
      csr_index <= CSR_BITS_PER_PIXEL;
      csr_wdata <= bpp;
      cfg_bits_per_pixel = bpp;
      @(negedge clock);
      csr_index <= CSR_MSB_PLANE_FIRST;
      csr_wdata <= msb_word;
      cfg_msb_first = msb_word[0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : req_sampler
      req_took = !reset && req_if.valid && req_if.ready;
      if (req_took) begin
         predict_pixels(req_if.data_byte, req_if.frame_start);
         bytes_taken++;
      end
   end

   always @(negedge clock) begin : req_driver
      plane_byte_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            nxt = byte_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.data_byte <= nxt.data_byte;
            req_if.frame_start <= nxt.frame_start;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 10);
               gap_left = $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver alternates ready and stall runs, sometimes a long ready stretch
   always @(negedge clock) begin : rsp_stall_pattern
      if (run_left == 0) begin
         run_ready = !run_ready;
         if (run_ready)
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 12);
         else
            run_left = $urandom_range(1, 6);
      end
      run_left--;
      rsp_if.ready <= run_ready;
   end

   always @(posedge clock) begin : pixel_monitor
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %02h last %0b",
                                      rsp_if.pixel_index, rsp_if.last_of_group));
         end else begin
            want = pixel_q.pop_front();
            if (rsp_if.pixel_index !== want.index)
               report_mismatch($sformatf("pixel_index got %02h want %02h",
                                         rsp_if.pixel_index, want.index));
            if (rsp_if.last_of_group !== want.last)
               report_mismatch($sformatf("last_of_group got %0b want %0b",
                                         rsp_if.last_of_group, want.last));
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] pb;
      logic [CFG_W-1:0] bpp;
      int budget;
      int n;
      int kind;
      int gsize;
      int len;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PLANE_BYTES;
      csr_wdata = '0;
      foreach (grp_buf[i]) grp_buf[i] = '0;
      grp_count = '0;
      cfg_plane_bytes = PLANE_BYTES_RST;
      cfg_bits_per_pixel = BITS_PER_PIXEL_RST;
      cfg_msb_first = 1'b1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: one byte per plane, four planes
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b0);
      // next group follows without a frame start
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      // partial group dropped by a frame start
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'hF0, 1'b1);
      queue_byte(8'h0F, 1'b0);
      queue_byte(8'hC3, 1'b0);
      queue_byte(8'h3C, 1'b0);
      wait_drained();

      // zero sizes act as one
      set_config(4'd0, 4'd0, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      wait_drained();

      // oversized plane length clamps to the maximum
      set_config(4'd15, 4'd1, 1'b1);
      for (int i = 0; i < 8; i++) queue_byte(8'h01 << i, i == 0);
      wait_drained();

      // oversized plane count clamps, then shrink the group mid-collection
      set_config(4'd1, 4'd15, 1'b0);
      queue_byte(8'hA5, 1'b1);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'hFF, 1'b0);
      wait_drained();
      set_config(4'd1, 4'd2, 1'b1);
      queue_byte(8'h81, 1'b0);
      wait_drained();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 0) begin
            pb = 4'd8;
            bpp = 4'd8;
            budget = 40;
         end else begin
            kind = $urandom_range(0, 9);
            pb = (kind == 0) ? 4'd0 : (kind == 1) ? CFG_W'($urandom_range(9, 15)) :
                 (kind == 2) ? 4'd8 : CFG_W'($urandom_range(1, 3));
            kind = $urandom_range(0, 9);
            bpp = (kind == 0) ? 4'd0 : (kind == 1) ? CFG_W'($urandom_range(9, 15)) :
                  (kind == 2) ? 4'd8 : CFG_W'($urandom_range(1, 4));
            budget = 16;
         end
         set_config(pb, bpp, 1'($urandom_range(0, 1)));
         gsize = clamp_cfg(pb, MAX_PLANE_BYTES) * clamp_cfg(bpp, MAX_PLANES);
         n = 0;
         while (n < budget) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               // well-formed group, usually opened by a frame start
               for (int i = 0; i < gsize; i++)
                  queue_byte(BYTE_W'($urandom_range(0, 255)),
                             i == 0 && $urandom_range(0, 3) != 0);
               n += gsize;
            end else if (kind < 9) begin
               // group of random length, at most a full one, opened by a frame start
               len = $urandom_range(1, gsize);
               for (int i = 0; i < len; i++)
                  queue_byte(BYTE_W'($urandom_range(0, 255)), i == 0);
               n += len;
            end else begin
               queue_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               n++;
            end
         end
         wait_drained();
      end

      wait_drained();
      if (pixel_q.size() != 0)
         report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
hdl/bp2pp_pkg.sv
hdl/bp2pp_if.sv
hdl/bp2pp_ram.sv
hdl/bp2pp_planes.sv
hdl/bp2pp_ctrl.sv
hdl/bitplane_to_packed_pixels.sv
dv/tb_bitplane_to_packed_pixels.sv
